FILE: rtl/core/efr_pkg.sv
// Shared types and constants for the edge filter and renumber block.
package efr_pkg;

  localparam int ID_W    = 31;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  localparam logic REG_USED_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic clear;
    logic rd_en;
  } lane_ctrl_t;

endpackage

FILE: rtl/core/efr_lane.sv
// One lane: a bank of the removed-identifier table with its compare and count logic.
module efr_lane #(
  parameter int ROWS  = 32,
  parameter int ROW_W = 5,
  parameter int CNT_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [ROW_W-1:0]         wr_row_i,
  input  logic [efr_pkg::ID_W-1:0] wr_data_i,
  input  efr_pkg::lane_ctrl_t      ctrl_i,
  input  logic [ROW_W-1:0]         rd_row_i,
  input  logic                     entry_vld_i,
  input  logic [efr_pkg::ID_W-1:0] node_a_i,
  input  logic [efr_pkg::ID_W-1:0] node_b_i,
  output logic                     hit_o,
  output logic [CNT_W-1:0]         cnt_a_o,
  output logic [CNT_W-1:0]         cnt_b_o
);

  logic [efr_pkg::ID_W-1:0] mem_q [ROWS];
  logic [efr_pkg::ID_W-1:0] rd_data_q;
  logic                     rd_vld_q;
  logic                     hit_q;
  logic [CNT_W-1:0]         cnt_a_q;
  logic [CNT_W-1:0]         cnt_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en & entry_vld_i;
      if (ctrl_i.clear) begin
        hit_q   <= 1'b0;
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end else if (rd_vld_q) begin
        hit_q   <= hit_q | (rd_data_q == node_a_i) | (rd_data_q == node_b_i);
        cnt_a_q <= cnt_a_q + CNT_W'(rd_data_q < node_a_i);
        cnt_b_q <= cnt_b_q + CNT_W'(rd_data_q < node_b_i);
      end
    end
  end

  assign hit_o   = hit_q;
  assign cnt_a_o = cnt_a_q;
  assign cnt_b_o = cnt_b_q;

endmodule

FILE: rtl/core/efr_merge.sv
// Merge stage: combines the lane hits and counts and registers the renumbered result.
module efr_merge #(
  parameter int LANES = 8,
  parameter int CNT_W = 6,
  parameter int SUM_W = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              capture_i,
  input  logic [LANES-1:0]                  hit_i,
  input  logic [LANES-1:0][CNT_W-1:0]       cnt_a_i,
  input  logic [LANES-1:0][CNT_W-1:0]       cnt_b_i,
  input  logic [efr_pkg::ID_W-1:0]          node_a_i,
  input  logic [efr_pkg::ID_W-1:0]          node_b_i,
  output logic [efr_pkg::ID_W-1:0]          new_a_o,
  output logic [efr_pkg::ID_W-1:0]          new_b_o,
  output logic                              done_o
);

  logic [SUM_W-1:0]         sum_a;
  logic [SUM_W-1:0]         sum_b;
  logic [efr_pkg::ID_W-1:0] new_a_d;
  logic [efr_pkg::ID_W-1:0] new_b_d;
  logic [efr_pkg::ID_W-1:0] new_a_q;
  logic [efr_pkg::ID_W-1:0] new_b_q;
  logic                     done_q;

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_a = sum_a + SUM_W'(cnt_a_i[l]);
      sum_b = sum_b + SUM_W'(cnt_b_i[l]);
    end
    if (32'(sum_a) > 32'(node_a_i)) begin
      new_a_d = '0;
    end else begin
      new_a_d = efr_pkg::ID_W'(32'(node_a_i) - 32'(sum_a));
    end
    if (32'(sum_b) > 32'(node_b_i)) begin
      new_b_d = '0;
    end else begin
      new_b_d = efr_pkg::ID_W'(32'(node_b_i) - 32'(sum_b));
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      new_a_q <= new_a_d;
      new_b_q <= new_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= capture_i & ~(|hit_i);
    end
  end

  assign new_a_o = new_a_q;
  assign new_b_o = new_b_q;
  assign done_o  = done_q;

endmodule

FILE: rtl/core/edge_filter_and_renumber.sv
// Top level: drops edges that touch removed nodes and renumbers the endpoints of the rest.
// A load beat leaves the block idle, and the block can take another beat in the next cycle.
// An edge beat sweeps R = ceil(n/LANES) rows of the table, one a cycle (one row when the used
// count n, capped at TABLE_DEPTH, is zero), then passes drain and merge. Only a kept edge
// raises the result strobe; the next beat can be taken at the edge that ends the strobe cycle.
// The receiver cannot stall. Reset clears used count and control; table contents stay undefined.
module edge_filter_and_renumber #(
  parameter int TABLE_DEPTH = 256,
  parameter int LANES       = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efr_pkg::ADDR_W-1:0]  paddr,
  input  logic [efr_pkg::DATA_W-1:0]  pwdata,
  output logic [efr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [efr_pkg::SLOT_W-1:0]  slot_i,
  input  logic [efr_pkg::ID_W-1:0]    node_a_i,
  input  logic [efr_pkg::ID_W-1:0]    node_b_i,
  output logic [efr_pkg::ID_W-1:0]    new_a_o,
  output logic [efr_pkg::ID_W-1:0]    new_b_o,
  output logic                        done_o
);

  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = (TABLE_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int N_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W  = $clog2(ROWS + 1);

  efr_pkg::state_e          state_q, state_d;
  efr_pkg::lane_ctrl_t      lane_ctrl;
  logic                     capture;
  logic [ROW_W-1:0]         row_q, row_d;
  logic [ROW_W-1:0]         last_row_q;
  logic [ROW_W-1:0]         last_row_d;
  logic [N_W-1:0]           n_q;
  logic [N_W-1:0]           n_d;
  logic [efr_pkg::ID_W-1:0] node_a_q;
  logic [efr_pkg::ID_W-1:0] node_b_q;
  logic [efr_pkg::COUNT_W-1:0] used_count_q;
  logic                     accept;
  logic                     edge_start;
  logic                     load_en;
  logic [ROW_W-1:0]         wr_row;
  logic [LANES-1:0]         entry_vld;
  logic [LANES-1:0]         lane_hit;
  logic [LANES-1:0][CNT_W-1:0] lane_cnt_a;
  logic [LANES-1:0][CNT_W-1:0] lane_cnt_b;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == efr_pkg::REG_USED_COUNT) ?
                  efr_pkg::DATA_W'(used_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_count_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == efr_pkg::REG_USED_COUNT) begin
      used_count_q <= pwdata[efr_pkg::COUNT_W-1:0];
    end
  end

  assign busy       = (state_q != efr_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign edge_start = accept && (kind_i == efr_pkg::KIND_EDGE);
  assign load_en    = accept && (kind_i == efr_pkg::KIND_LOAD) &&
                      (32'(slot_i) < 32'(TABLE_DEPTH));
  assign wr_row     = ROW_W'(slot_i >> LANE_W);

  assign n_d = (32'(used_count_q) > 32'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH)
                                                       : N_W'(used_count_q);
  assign last_row_d = (n_d == '0) ? '0 : ROW_W'((32'(n_d) - 32'd1) >> LANE_W);

  always_ff @(posedge clk_i) begin
    if (edge_start) begin
      node_a_q   <= node_a_i;
      node_b_q   <= node_b_i;
      n_q        <= n_d;
      last_row_q <= last_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efr_pkg::ST_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    lane_ctrl = '0;
    capture   = 1'b0;
    unique case (state_q)
      efr_pkg::ST_IDLE: begin
        if (edge_start) begin
          state_d         = efr_pkg::ST_SWEEP;
          row_d           = '0;
          lane_ctrl.clear = 1'b1;
        end
      end
      efr_pkg::ST_SWEEP: begin
        lane_ctrl.rd_en = 1'b1;
        if (row_q == last_row_q) begin
          state_d = efr_pkg::ST_DRAIN;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      efr_pkg::ST_DRAIN: begin
        state_d = efr_pkg::ST_MERGE;
      end
      efr_pkg::ST_MERGE: begin
        capture = 1'b1;
        state_d = efr_pkg::ST_IDLE;
      end
      default: begin
        state_d = efr_pkg::ST_IDLE;
      end
    endcase
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign entry_vld[l] = 32'({row_q, LANE_W'(l)}) < 32'(n_q);

    efr_lane #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W),
      .CNT_W (CNT_W)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (load_en && (slot_i[LANE_W-1:0] == LANE_W'(l))),
      .wr_row_i    (wr_row),
      .wr_data_i   (node_a_i),
      .ctrl_i      (lane_ctrl),
      .rd_row_i    (row_q),
      .entry_vld_i (entry_vld[l]),
      .node_a_i    (node_a_q),
      .node_b_i    (node_b_q),
      .hit_o       (lane_hit[l]),
      .cnt_a_o     (lane_cnt_a[l]),
      .cnt_b_o     (lane_cnt_b[l])
    );
  end

  efr_merge #(
    .LANES (LANES),
    .CNT_W (CNT_W),
    .SUM_W (N_W)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .capture_i (capture),
    .hit_i     (lane_hit),
    .cnt_a_i   (lane_cnt_a),
    .cnt_b_i   (lane_cnt_b),
    .node_a_i  (node_a_q),
    .node_b_i  (node_b_q),
    .new_a_o   (new_a_o),
    .new_b_o   (new_b_o),
    .done_o    (done_o)
  );

endmodule

FILE: rtl/core/efr_checker.sv
// Port-level checker for the edge filter and renumber block, bound to its top level.
module efr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic kind_i,
  input logic done_o
);

  property p_no_back_to_back_done;
    @(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o;
  endproperty
  a_no_back_to_back_done: assert property (p_no_back_to_back_done)
    else $error("Result strobe was high in two consecutive cycles.");

  property p_done_only_when_free;
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy;
  endproperty
  a_done_only_when_free: assert property (p_done_only_when_free)
    else $error("Result strobe appeared while the block was busy.");

  property p_load_keeps_free;
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && kind_i == efr_pkg::KIND_LOAD) |=> !busy && !done_o;
  endproperty
  a_load_keeps_free: assert property (p_load_keeps_free)
    else $error("A load beat made the block busy or produced a result.");

  property p_edge_latency;
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && kind_i == efr_pkg::KIND_EDGE) |=>
        busy && !done_o ##1 busy && !done_o ##1 busy && !done_o;
  endproperty
  a_edge_latency: assert property (p_edge_latency)
    else $error("An edge beat did not hold the block busy for its sweep.");

endmodule

bind edge_filter_and_renumber efr_checker u_efr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .kind_i (kind_i),
  .done_o (done_o)
);

FILE: tb/tb_top.sv
// Self-checking testbench for edge_filter_and_renumber: table loads, edge filtering, renumbering.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int LANES       = 8;
  localparam int SETTLE      = TABLE_DEPTH / LANES + 8;
  localparam logic [efr_pkg::ID_W-1:0] ID_MAX = {efr_pkg::ID_W{1'b1}};
  localparam logic [efr_pkg::ADDR_W-1:0] USED_COUNT_ADDR = {efr_pkg::REG_USED_COUNT, 2'b00};

  typedef struct packed {
    logic                       kind;
    logic [efr_pkg::SLOT_W-1:0] slot;
    logic [efr_pkg::ID_W-1:0]   node_a;
    logic [efr_pkg::ID_W-1:0]   node_b;
  } beat_t;

  typedef struct packed {
    logic [efr_pkg::ID_W-1:0] a;
    logic [efr_pkg::ID_W-1:0] b;
  } renum_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [efr_pkg::ADDR_W-1:0] paddr = '0;
  logic [efr_pkg::DATA_W-1:0] pwdata = '0;
  logic [efr_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic kind_i = efr_pkg::KIND_LOAD;
  logic [efr_pkg::SLOT_W-1:0] slot_i = '0;
  logic [efr_pkg::ID_W-1:0] node_a_i = '0;
  logic [efr_pkg::ID_W-1:0] node_b_i = '0;
  logic [efr_pkg::ID_W-1:0] new_a_o;
  logic [efr_pkg::ID_W-1:0] new_b_o;
  logic done_o;

  edge_filter_and_renumber #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .LANES      (LANES)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .kind_i  (kind_i),
    .slot_i  (slot_i),
    .node_a_i(node_a_i),
    .node_b_i(node_b_i),
    .new_a_o (new_a_o),
    .new_b_o (new_b_o),
    .done_o  (done_o)
  );

  beat_t  beat_q[$];
  renum_t renum_q[$];

  logic [efr_pkg::ID_W-1:0]    removed_tbl [TABLE_DEPTH];
  logic [efr_pkg::COUNT_W-1:0] used_mirror = '0;
  logic [efr_pkg::ID_W-1:0]    gen_tbl [TABLE_DEPTH];
  int unsigned                 gen_used = 0;

  logic   took = 1'b0;
  beat_t  cur_beat;
  renum_t exp_r;
  renum_t got_r;
  int     live;
  int     beats_sent = 0;
  int     errs = 0;
  int     n_loads = 0;
  int     n_edges = 0;
  int     n_kept = 0;
  int     n_dropped = 0;
  int     n_cfg = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results still expected.", renum_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit id_removed(input logic [efr_pkg::ID_W-1:0] id, input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (removed_tbl[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [efr_pkg::ID_W-1:0] compact_id(input logic [efr_pkg::ID_W-1:0] id,
                                                         input int n);
    int unsigned below;
    int i;
    below = 0;
    for (i = 0; i < n; i++) begin
      if (removed_tbl[i] < id) below++;
    end
    return (below > id) ? '0 : efr_pkg::ID_W'(id - below);
  endfunction

  // Driver: a beat is held on the inputs until the block takes it.
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took)) begin
      if (beat_q.size() != 0 &&
          ((beats_sent >= 320 && beats_sent < 470) || $urandom_range(99) >= 12)) begin
        cur_beat = beat_q.pop_front();
        start    <= 1'b1;
        kind_i   <= cur_beat.kind;
        slot_i   <= cur_beat.slot;
        node_a_i <= cur_beat.node_a;
        node_b_i <= cur_beat.node_b;
        beats_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor: results are checked before the beat taken at the same edge is predicted.
  always @(posedge clk_i) begin
    took = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        got_r.a = new_a_o;
        got_r.b = new_b_o;
        if (renum_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("Unexpected result: new_a=%0d new_b=%0d", got_r.a, got_r.b);
        end else begin
          exp_r = renum_q.pop_front();
          n_kept++;
          if (got_r.a !== exp_r.a || got_r.b !== exp_r.b) begin
            errs++;
            if (errs <= 10)
              $display("Mismatch: new_a=%0d (expected %0d), new_b=%0d (expected %0d)",
                       got_r.a, exp_r.a, got_r.b, exp_r.b);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == USED_COUNT_ADDR)
        used_mirror = pwdata[efr_pkg::COUNT_W-1:0];
      if (start && !busy) begin
        took = 1'b1;
        if (kind_i == efr_pkg::KIND_LOAD) begin
          removed_tbl[slot_i] = node_a_i;
          n_loads++;
        end else begin
          n_edges++;
          live = (used_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(used_mirror);
          if (id_removed(node_a_i, live) || id_removed(node_b_i, live)) begin
            n_dropped++;
          end else begin
            exp_r.a = compact_id(node_a_i, live);
            exp_r.b = compact_id(node_b_i, live);
            renum_q.push_back(exp_r);
          end
        end
      end
    end
  end

  task automatic push_load(input int unsigned slot, input logic [efr_pkg::ID_W-1:0] val);
    beat_t b;
    b.kind   = efr_pkg::KIND_LOAD;
    b.slot   = slot[efr_pkg::SLOT_W-1:0];
    b.node_a = val;
    b.node_b = efr_pkg::ID_W'($urandom());
    gen_tbl[slot[efr_pkg::SLOT_W-1:0]] = val;
    beat_q.push_back(b);
  endtask

  task automatic push_edge(input logic [efr_pkg::ID_W-1:0] a, input logic [efr_pkg::ID_W-1:0] b);
    beat_t e;
    e.kind   = efr_pkg::KIND_EDGE;
    e.slot   = efr_pkg::SLOT_W'($urandom_range(TABLE_DEPTH - 1));
    e.node_a = a;
    e.node_b = b;
    beat_q.push_back(e);
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || start) @(posedge clk_i);
    while (renum_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_used(input int unsigned v);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= USED_COUNT_ADDR;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[efr_pkg::COUNT_W-1:0] !== v[efr_pkg::COUNT_W-1:0]) begin
      errs++;
      if (errs <= 10)
        $display("Readback of used_count: got %0d, expected %0d",
                 prdata[efr_pkg::COUNT_W-1:0], v);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    gen_used = v;
    n_cfg++;
  endtask

  function automatic logic [efr_pkg::ID_W-1:0] pick_id();
    int r;
    int span;
    r    = $urandom_range(99);
    span = (gen_used > TABLE_DEPTH) ? TABLE_DEPTH : int'(gen_used);
    if (r < 60) return efr_pkg::ID_W'($urandom_range(2100));
    if (r < 78 && span > 0) return gen_tbl[efr_pkg::SLOT_W'($urandom_range(span - 1))];
    if (r < 85) return efr_pkg::ID_W'(ID_MAX - $urandom_range(3));
    return efr_pkg::ID_W'($urandom());
  endfunction

  function automatic logic [efr_pkg::ID_W-1:0] pick_stored();
    if ($urandom_range(99) < 80) return efr_pkg::ID_W'($urandom_range(2000));
    return efr_pkg::ID_W'($urandom());
  endfunction

  initial begin
    int unsigned phase_used [8];
    int p;
    int k;
    phase_used = '{256, 511, 1, 257, 128, 0, 9, 0};
    phase_used[5] = $urandom_range(2, 255);
    phase_used[7] = $urandom_range(0, 511);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With an empty active table every edge is kept unchanged.
    set_used(0);
    push_edge(0, 0);
    push_edge(ID_MAX, ID_MAX);
    push_edge(0, ID_MAX);
    push_edge(31'h2AAAAAAA, 31'h55555555);
    push_load(0, 5);
    push_load(1, 0);
    push_load(2, 0);
    push_load(3, ID_MAX);
    push_load(TABLE_DEPTH - 1, 31'h55555555);

    // Table {5, 0, 0, max}: drops, duplicate zeros and saturation at zero.
    set_used(4);
    push_edge(5, 6);
    push_edge(6, 1);
    push_edge(ID_MAX - 1, 7);
    push_edge(0, 9);
    push_edge(9, ID_MAX);
    push_edge(2, 3);
    push_edge(1, 1);
    push_load(0, 100);
    push_edge(5, 100);
    push_edge(101, 5);

    for (k = 0; k < TABLE_DEPTH; k++) push_load(k, pick_stored());

    for (p = 0; p < 8; p++) begin
      set_used(phase_used[p]);
      for (k = 0; k < 62; k++) begin
        if ($urandom_range(99) < 15) push_load($urandom_range(TABLE_DEPTH - 1), pick_stored());
        else push_edge(pick_id(), pick_id());
      end
    end

    drain();
    if (renum_q.size() != 0) begin
      errs += renum_q.size();
      $display("%0d expected results never arrived.", renum_q.size());
    end
    $display("Run covered %0d edge beats (%0d kept, %0d dropped) and %0d table loads,",
             n_edges, n_kept, n_dropped, n_loads);
    $display("over %0d used_count settings including zero, full table and beyond.", n_cfg);
    if (errs == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total.", errs);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: edge_filter_and_renumber.f
rtl/core/efr_pkg.sv
rtl/core/efr_lane.sv
rtl/core/efr_merge.sv
rtl/core/edge_filter_and_renumber.sv
rtl/core/efr_checker.sv
tb/tb_top.sv
